>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

// invariant
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

>>> design/etfp_pkg.sv
// ----------------------------------------------------------------------------
// etfp_pkg
// Widths, constants, payload types and control types of the fractal pixel.
// ----------------------------------------------------------------------------
`default_nettype none

package etfp_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int IMG_WIDTH  = 1024;
  localparam int IMG_HEIGHT = 1024;

  localparam int PIX_W     = 10;
  localparam int ITER_W    = 12;
  localparam int ZOOM_W    = 31;
  localparam int COLOR_W   = 24;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // working word: Q4.FRAC_BITS signed
  localparam int W     = FRAC_BITS + 4;
  localparam int NUM_W = PIX_W + FRAC_BITS + 2;

  // largest mapped quotient on either axis
  localparam longint MAPQ_X =
    ((longint'(1) << PIX_W) - 1) * (longint'(4) << FRAC_BITS) / IMG_WIDTH;
  localparam longint MAPQ_Y =
    ((longint'(1) << PIX_W) - 1) * (longint'(4) << FRAC_BITS) / IMG_HEIGHT;
  localparam longint MAPQ   = (MAPQ_X > MAPQ_Y) ? MAPQ_X : MAPQ_Y;
  localparam int MAPQ_BITS  = $clog2(MAPQ + 1);
  localparam int MAP_W      = ((MAPQ_BITS > FRAC_BITS + 1) ? MAPQ_BITS : FRAC_BITS + 1) + 1;

  localparam int MUL_W0  = (W > MAP_W) ? W : MAP_W;
  localparam int MUL_W   = (MUL_W0 > ZOOM_W + 1) ? MUL_W0 : ZOOM_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int TRUNC_W = PROD_W - FRAC_BITS;

  localparam logic signed [MAP_W-1:0] MAP_TWO  = MAP_W'(longint'(2) << FRAC_BITS);
  localparam logic signed [W:0]       FOUR_FX  = (W + 1)'(longint'(4) << FRAC_BITS);

  // colour ramp 0x00FFFF * i / n
  localparam int Q_W   = 16;
  localparam int CNT_W = $clog2(Q_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM         = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y      = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_RE     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_IM     = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_COLOR = CFG_IDX_W'(7);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0]   out_x;
    logic [PIX_W-1:0]   out_y;
    logic               escaped;
    logic [ITER_W-1:0]  iter_count;
    logic [COLOR_W-1:0] pixel_color;
  } result_t;

  typedef enum logic [2:0] {
    MUL_MX,
    MUL_MY,
    MUL_RR,
    MUL_II,
    MUL_RI
  } mul_sel_t;

  typedef enum logic [2:0] {
    POST_NONE,
    POST_ZR0,
    POST_ZI0,
    POST_A,
    POST_B,
    POST_C
  } post_op_t;

  typedef struct packed {
    logic      start;
    mul_sel_t  mul_sel;
    post_op_t  post_op;
    logic      set_esc;
    logic      inc_i;
    logic      div_init;
    logic      div_step;
    logic      load_result;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic gt4;
    logic last_iter;
    logic n_zero;
    logic i_zero;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

>>> design/etfp_if.sv
// ----------------------------------------------------------------------------
// etfp stream interfaces
// Valid/ready channels for pixel beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface etfp_pixel_if;
  logic            valid;
  logic            ready;
  etfp_pkg::pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface etfp_result_if;
  logic             valid;
  logic             ready;
  etfp_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/escape_time_fractal_pixel_top.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_top
// Escape-time Mandelbrot/Julia pixel engine, Q4.28 fixed point.
// ----------------------------------------------------------------------------
//
//   channel   dir  beat                                      handshake
//   pixel     in   pixel_x, pixel_y                          valid/ready
//   result    out  out_x, out_y, escaped, iter_count, colour valid/ready
//   cfg       in   cfg_index, cfg_data                       cfg_we, no wait
//
// Throughput: one pixel at a time. Each pixel runs setup and its iterations,
// then the colour ramp division when it escapes after the first iteration.
// The pace is set by the single 32x32 multiplier with a registered product,
// used three times per iteration.
// Reset: config registers take their reset values, the sequencer goes idle.
// Stalls: the finished beat sits in the result register while the next
// pixel is taken; a new result waits in the sequencer until that beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module escape_time_fractal_pixel_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [etfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [etfp_pkg::CFG_W-1:0]     cfg_data,
  etfp_pixel_if.sink                          pixel,
  etfp_result_if.source                       result
);

  etfp_pkg::cmd_t    cmd;
  etfp_pkg::status_t status;
  etfp_pkg::result_t res;

  // sequencer: owns the handshakes and the result valid flag
  etfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: config, multiplier, iterates, divider, result payload
  etfp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pixel.data),
    .cmd       (cmd),
    .status    (status),
    .res       (res)
  );

  assign result.data = res;

  // escaped beat on offer with a count of zero
  logic esc_at_zero;

  assign esc_at_zero = result.valid && result.data.escaped && (result.data.iter_count == '0);

  // one pixel in flight: busy right after a beat is taken
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, pixel.valid && pixel.ready, !pixel.ready)
  // a finished result never overwrites a beat still waiting
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.load_result, !result.valid || result.ready)
  // escape at the first step sits at the black end of the ramp
  `ASSERT_IMPLIES(a_escape_zero_black, clk, rst, esc_at_zero, result.data.pixel_color == '0)

endmodule

`default_nettype wire

>>> design/etfp_ctrl.sv
// ----------------------------------------------------------------------------
// etfp_ctrl
// Sequencer: setup, iteration schedule over the shared multiplier, ramp
// division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module etfp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  input  wire etfp_pkg::status_t status,
  output      etfp_pkg::cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_MX   = 14'b00000000000010,
    S_MY   = 14'b00000000000100,
    S_ZI0  = 14'b00000000001000,
    S_CHK0 = 14'b00000000010000,
    S_RR   = 14'b00000000100000,
    S_II   = 14'b00000001000000,
    S_B    = 14'b00000010000000,
    S_TEST = 14'b00000100000000,
    S_RI   = 14'b00001000000000,
    S_C    = 14'b00010000000000,
    S_DIVI = 14'b00100000000000,
    S_DIV  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   first, first_next;
  logic   out_valid_next;

  always_comb begin
    cmd.start       = 1'b0;
    cmd.mul_sel     = etfp_pkg::MUL_MX;
    cmd.post_op     = etfp_pkg::POST_NONE;
    cmd.set_esc     = 1'b0;
    cmd.inc_i       = 1'b0;
    cmd.div_init    = 1'b0;
    cmd.div_step    = 1'b0;
    cmd.load_result = 1'b0;
    state_next      = state;
    first_next      = first;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_MX;
        end
      end
      S_MX: begin
        cmd.mul_sel = etfp_pkg::MUL_MX;
        state_next  = S_MY;
      end
      S_MY: begin
        cmd.mul_sel = etfp_pkg::MUL_MY;
        cmd.post_op = etfp_pkg::POST_ZR0;
        state_next  = S_ZI0;
      end
      S_ZI0: begin
        cmd.post_op = etfp_pkg::POST_ZI0;
        state_next  = S_CHK0;
      end
      S_CHK0: begin
        // z0 or c out of range: escape before any iteration
        if (status.ovf) begin
          cmd.set_esc = 1'b1;
          state_next  = S_OUT;
        end else if (status.n_zero) begin
          state_next = S_OUT;
        end else begin
          first_next = 1'b1;
          state_next = S_RR;
        end
      end
      S_RR: begin
        cmd.mul_sel = etfp_pkg::MUL_RR;
        state_next  = S_II;
      end
      S_II: begin
        cmd.mul_sel = etfp_pkg::MUL_II;
        cmd.post_op = etfp_pkg::POST_A;
        state_next  = S_B;
      end
      S_B: begin
        cmd.post_op = etfp_pkg::POST_B;
        state_next  = S_TEST;
      end
      S_TEST: begin
        // first pass only checks the squares of z0
        if (status.ovf || (!first && status.gt4)) begin
          cmd.set_esc = 1'b1;
          state_next  = status.i_zero ? S_OUT : S_DIVI;
        end else if (first) begin
          first_next = 1'b0;
          state_next = S_RI;
        end else if (status.last_iter) begin
          state_next = S_OUT;
        end else begin
          cmd.inc_i  = 1'b1;
          state_next = S_RI;
        end
      end
      S_RI: begin
        cmd.mul_sel = etfp_pkg::MUL_RI;
        state_next  = S_C;
      end
      S_C: begin
        cmd.post_op = etfp_pkg::POST_C;
        state_next  = S_RR;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready       = (state == S_IDLE);
  assign out_valid_next = cmd.load_result || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      first     <= first_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> design/etfp_dp.sv
// ----------------------------------------------------------------------------
// etfp_dp
// Datapath: config registers, shared multiplier with truncating post stage,
// iterate registers, ramp divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module etfp_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [etfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [etfp_pkg::CFG_W-1:0]          cfg_data,
  input  wire etfp_pkg::pixel_t                    pix_in,
  input  wire etfp_pkg::cmd_t                      cmd,
  output      etfp_pkg::status_t                   status,
  output      etfp_pkg::result_t                   res
);

  localparam int W       = etfp_pkg::W;
  localparam int F       = etfp_pkg::FRAC_BITS;
  localparam int MUL_W   = etfp_pkg::MUL_W;
  localparam int PROD_W  = etfp_pkg::PROD_W;
  localparam int TRUNC_W = etfp_pkg::TRUNC_W;
  localparam int MAP_W   = etfp_pkg::MAP_W;
  localparam int NUM_W   = etfp_pkg::NUM_W;
  localparam int ITER_W  = etfp_pkg::ITER_W;
  localparam int Q_W     = etfp_pkg::Q_W;
  localparam int CNT_W   = etfp_pkg::CNT_W;
  localparam int PIX_W   = etfp_pkg::PIX_W;
  localparam int COLOR_W = etfp_pkg::COLOR_W;
  localparam int DNUM_W  = ITER_W + Q_W;

  // config
  logic                                  mode;
  logic [ITER_W-1:0]                     max_iter;
  logic [etfp_pkg::ZOOM_W-1:0]           zoom;
  logic signed [etfp_pkg::CFG_W-1:0]     shift_x, shift_y, julia_re, julia_im;
  logic [COLOR_W-1:0]                    inside_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      max_iter     <= ITER_W'(100);
      zoom         <= etfp_pkg::ZOOM_W'(268435456);
      shift_x      <= '0;
      shift_y      <= '0;
      julia_re     <= '0;
      julia_im     <= '0;
      inside_color <= COLOR_W'(24'hFFFF00);
    end else if (cfg_we) begin
      unique case (cfg_index)
        etfp_pkg::CFG_MODE:         mode         <= cfg_data[0];
        etfp_pkg::CFG_MAX_ITER:     max_iter     <= cfg_data[ITER_W-1:0];
        etfp_pkg::CFG_ZOOM:         zoom         <= cfg_data[etfp_pkg::ZOOM_W-1:0];
        etfp_pkg::CFG_SHIFT_X:      shift_x      <= cfg_data;
        etfp_pkg::CFG_SHIFT_Y:      shift_y      <= cfg_data;
        etfp_pkg::CFG_JULIA_RE:     julia_re     <= cfg_data;
        etfp_pkg::CFG_JULIA_IM:     julia_im     <= cfg_data;
        etfp_pkg::CFG_INSIDE_COLOR: inside_color <= cfg_data[COLOR_W-1:0];
      endcase
    end
  end

  // working registers
  logic [PIX_W-1:0]         px, py;
  logic signed [W-1:0]      zr, zi, cr, ci, sq_a, sq_b;
  logic signed [PROD_W-1:0] prod;
  logic                     ovf, esc;
  logic [ITER_W-1:0]        iter;
  logic [ITER_W-1:0]        rem;
  logic [Q_W-1:0]           dq;
  logic [CNT_W-1:0]         dcnt;

  // pixel to [-2,2)
  logic [NUM_W-1:0]         num_x, num_y, quo_x, quo_y;
  logic signed [MAP_W-1:0]  map_x, map_y;

  assign num_x = NUM_W'(px) << (F + 2);
  assign num_y = NUM_W'(py) << (F + 2);
  assign quo_x = NUM_W'(num_x / etfp_pkg::IMG_WIDTH);
  assign quo_y = NUM_W'(num_y / etfp_pkg::IMG_HEIGHT);
  assign map_x = signed'(quo_x[MAP_W-1:0]) - etfp_pkg::MAP_TWO;
  assign map_y = signed'(quo_y[MAP_W-1:0]) - etfp_pkg::MAP_TWO;

  // shared multiplier, product registered
  logic signed [MUL_W-1:0] op_a, op_b;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      etfp_pkg::MUL_MX: begin
        op_a = MUL_W'(map_x);
        op_b = signed'(MUL_W'(zoom));
      end
      etfp_pkg::MUL_MY: begin
        op_a = MUL_W'(map_y);
        op_b = signed'(MUL_W'(zoom));
      end
      etfp_pkg::MUL_RR: begin
        op_a = MUL_W'(zr);
        op_b = MUL_W'(zr);
      end
      etfp_pkg::MUL_II: begin
        op_a = MUL_W'(zi);
        op_b = MUL_W'(zi);
      end
      etfp_pkg::MUL_RI: begin
        op_a = MUL_W'(zr);
        op_b = MUL_W'(zi);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // truncate toward zero, then range check against the working word
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [TRUNC_W-1:0] t_full;
  logic                      t_fix, t_ok;
  logic signed [W-1:0]       t;

  assign prod_sh = prod >>> F;
  assign t_fix   = prod[PROD_W-1] && (prod[F-1:0] != '0);
  assign t_full  = prod_sh[TRUNC_W-1:0] + TRUNC_W'(t_fix);
  assign t_ok    = (&t_full[TRUNC_W-1:W-1]) || !(|t_full[TRUNC_W-1:W-1]);
  assign t       = t_full[W-1:0];

  // z0 = mapped * zoom + pan
  logic signed [W-1:0] pan;
  logic signed [W:0]   z0_sum;
  logic                z0_ok;

  assign pan    = (cmd.post_op == etfp_pkg::POST_ZR0) ? W'(shift_x) : W'(shift_y);
  assign z0_sum = (W + 1)'(t) + (W + 1)'(pan);
  assign z0_ok  = (z0_sum[W] == z0_sum[W-1]);

  // z^2 + c
  logic signed [W+1:0] nr, ni;
  logic                nr_ok, ni_ok;

  assign nr    = (W + 2)'(sq_a) - (W + 2)'(sq_b) + (W + 2)'(cr);
  assign ni    = ((W + 2)'(t) <<< 1) + (W + 2)'(ci);
  assign nr_ok = (&nr[W+1:W-1]) || !(|nr[W+1:W-1]);
  assign ni_ok = (&ni[W+1:W-1]) || !(|ni[W+1:W-1]);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px   <= pix_in.pixel_x;
      py   <= pix_in.pixel_y;
      ovf  <= 1'b0;
      esc  <= 1'b0;
      iter <= '0;
    end else begin
      if (cmd.set_esc) begin
        esc <= 1'b1;
      end
      if (cmd.inc_i) begin
        iter <= iter + 1'b1;
      end
      case (cmd.post_op)
        etfp_pkg::POST_ZR0: begin
          zr  <= z0_sum[W-1:0];
          ovf <= ovf || !t_ok || !z0_ok;
        end
        etfp_pkg::POST_ZI0: begin
          zi  <= z0_sum[W-1:0];
          cr  <= mode ? W'(julia_re) : zr;
          ci  <= mode ? W'(julia_im) : z0_sum[W-1:0];
          ovf <= ovf || !t_ok || !z0_ok;
        end
        etfp_pkg::POST_A: begin
          sq_a <= t;
          ovf  <= ovf || !t_ok;
        end
        etfp_pkg::POST_B: begin
          sq_b <= t;
          ovf  <= ovf || !t_ok;
        end
        etfp_pkg::POST_C: begin
          zr  <= nr[W-1:0];
          zi  <= ni[W-1:0];
          ovf <= ovf || !t_ok || !nr_ok || !ni_ok;
        end
        default: begin
        end
      endcase
    end
  end

  // ramp divider: q = (2^Q_W - 1) * iter / max_iter, one bit a cycle
  logic [DNUM_W-1:0] dnum;
  logic [ITER_W:0]   trial, diff;
  logic              ge;

  assign dnum  = {iter, Q_W'(0)} - DNUM_W'(iter);
  assign trial = {rem, dq[Q_W-1]};
  assign diff  = trial - {1'b0, max_iter};
  assign ge    = (trial >= {1'b0, max_iter});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= dnum[DNUM_W-1:Q_W];
      dq   <= dnum[Q_W-1:0];
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? diff[ITER_W-1:0] : trial[ITER_W-1:0];
      dq   <= {dq[Q_W-2:0], ge};
      dcnt <= dcnt + 1'b1;
    end
  end

  // result register
  logic [COLOR_W-1:0] ramp_color;

  assign ramp_color = (iter == '0) ? '0 : {(COLOR_W - Q_W)'(0), dq};

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res.out_x       <= px;
      res.out_y       <= py;
      res.escaped     <= esc;
      res.iter_count  <= esc ? iter : max_iter;
      res.pixel_color <= esc ? ramp_color : inside_color;
    end
  end

  // status
  logic signed [W:0] sum_ab;

  assign sum_ab           = (W + 1)'(sq_a) + (W + 1)'(sq_b);
  assign status.ovf       = ovf;
  assign status.gt4       = (sum_ab > etfp_pkg::FOUR_FX);
  assign status.last_iter = (ITER_W'(iter + 1'b1) == max_iter);
  assign status.n_zero    = (max_iter == '0);
  assign status.i_zero    = (iter == '0);
  assign status.div_last  = (dcnt == CNT_W'(Q_W - 1));

endmodule

`default_nettype wire

>>> verif/escape_time_fractal_pixel_top_test.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_top_test
// Self-checking bench for the escape-time pixel engine. Pixel beats go in
// from a queue through a clocked driver. Each accepted beat is scored by an
// in-bench Q4.28 iteration of the Mandelbrot/Julia map. A clocked monitor
// compares every result beat field by field, in order. Directed corners and
// overflow cases come first, then randomised register settings with
// random pixels and random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_fractal_pixel_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import etfp_pkg::*;

  // mode register codes
  localparam logic [CFG_W-1:0] MANDELBROT = CFG_W'(0);
  localparam logic [CFG_W-1:0] JULIA      = CFG_W'(1);

  // working word limits and 1.0 in Q4.28
  localparam longint WORD_MAX = (longint'(1) <<< (W - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam longint FX_ONE   = longint'(1) <<< FRAC_BITS;

  // The slowest legal run has every pixel running 160 iterations with the longest gaps,
  // plus the 4095-iteration pixel. The limit sits well above that run.
  localparam int unsigned RUN_LIMIT = 3_000_000;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  etfp_pixel_if  pix ();
  etfp_result_if res ();

  escape_time_fractal_pixel_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix),
    .result    (res)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Bench copy of the registers: these are the reset values, and they follow every write.
  logic                      julia_on   = 1'b0;
  logic [ITER_W-1:0]         iter_limit = ITER_W'(100);
  logic [ZOOM_W-1:0]         zoom_q     = ZOOM_W'(32'h1000_0000);
  logic signed [CFG_W-1:0]   pan_x      = '0;
  logic signed [CFG_W-1:0]   pan_y      = '0;
  logic signed [CFG_W-1:0]   jul_re     = '0;
  logic signed [CFG_W-1:0]   jul_im     = '0;
  logic [COLOR_W-1:0]        inside_rgb = COLOR_W'(24'hFFFF00);

  pixel_t      pending[$];    // pixels not yet offered
  result_t     awaited[$];    // outcomes of accepted pixels, oldest first
  bit          gaps_on   = 1'b0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------- arithmetic

  function automatic bit fits_word(input longint v);
    return v >= WORD_MIN && v <= WORD_MAX;
  endfunction

  // The product is truncated towards zero. It returns 0 when the product
  // leaves the working word.
  function automatic bit fx_mul(input longint a, input longint b, output longint r);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] mag;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? 128'(-a) : 128'(a);
    mb  = (b < 0) ? 128'(-b) : 128'(b);
    mag = (ma * mb) >> FRAC_BITS;
    r   = 0;
    if (mag > 128'(WORD_MAX) + 1) return 1'b0;
    r = neg ? -longint'(mag) : longint'(mag);
    return fits_word(r);
  endfunction

  // The pixel index is mapped linearly onto [-2,2). The quotient is floored.
  function automatic longint map_axis(input logic [PIX_W-1:0] p, input longint dim);
    return ((longint'(4) <<< FRAC_BITS) * longint'(p)) / dim - (longint'(2) <<< FRAC_BITS);
  endfunction

  // The outcome of one pixel under the registers currently held in the bench.
  function automatic result_t escape_outcome(input pixel_t px);
    longint      zr, zi, cr, ci, sq_r, sq_i, prod_ri, nr, ni;
    int unsigned it, n;
    bit          ok, esc;
    result_t     r;
    n   = 32'(iter_limit);
    it  = 0;
    esc = 1'b0;
    cr  = 0;
    ci  = 0;
    zi  = 0;
    ok  = fx_mul(map_axis(px.pixel_x, longint'(IMG_WIDTH)), longint'(zoom_q), zr);
    if (ok) ok = fx_mul(map_axis(px.pixel_y, longint'(IMG_HEIGHT)), longint'(zoom_q), zi);
    if (ok) begin
      zr = zr + longint'(pan_x);
      zi = zi + longint'(pan_y);
      ok = fits_word(zr) && fits_word(zi);
    end
    if (ok) begin
      cr = julia_on ? longint'(jul_re) : zr;
      ci = julia_on ? longint'(jul_im) : zi;
      ok = fits_word(cr) && fits_word(ci);
    end
    if (!ok) begin
      esc = 1'b1;   // z0 or c out of range: escape before the first step
    end else begin
      for (it = 0; it < n; it++) begin
        if (!fx_mul(zr, zr, sq_r) || !fx_mul(zi, zi, sq_i) || !fx_mul(zr, zi, prod_ri)) begin
          esc = 1'b1;
          break;
        end
        nr = sq_r - sq_i + cr;
        ni = 2 * prod_ri + ci;
        if (!fits_word(nr) || !fits_word(ni)) begin
          esc = 1'b1;
          break;
        end
        zr = nr;
        zi = ni;
        if (!fx_mul(zr, zr, sq_r) || !fx_mul(zi, zi, sq_i) || sq_r + sq_i > 4 * FX_ONE) begin
          esc = 1'b1;
          break;
        end
      end
    end
    r.out_x   = px.pixel_x;
    r.out_y   = px.pixel_y;
    r.escaped = esc;
    if (esc) begin
      r.iter_count  = ITER_W'(it);
      r.pixel_color = (n != 0) ? COLOR_W'((longint'(24'h00FFFF) * it) / n) : '0;
    end else begin
      r.iter_count  = ITER_W'(n);
      r.pixel_color = inside_rgb;
    end
    return r;
  endfunction

  // ------------------------------------------------------------------ checking

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want_v, input result_t want);
    if (got !== want_v)
      flag_mismatch($sformatf("pixel (%0d,%0d) %s: got 0x%0h, want 0x%0h",
                              want.out_x, want.out_y, name, got, want_v));
  endtask

  // ----------------------------------------------------- pixel driver (source)
  // The driver offers the head of the pending queue. It keeps data steady while a beat
  // is stalled. At random it stops offering until a random idle count runs out.
  always @(posedge clk) begin : pixel_driver
    logic   drive_valid;
    pixel_t drive_beat;
    if (rst) begin
      pix.valid <= 1'b0;
      send_idle = 0;
    end else begin
      // The outcome is scored when the beat is accepted, with the registers as they are now.
      if (pix.valid && pix.ready) awaited.push_back(escape_outcome(pix.data));
      if (!pix.valid || pix.ready) begin
        drive_valid = 1'b0;
        drive_beat  = pix.data;
        if (send_idle > 0) begin
          send_idle--;
        end else if (pending.size() != 0) begin
          if (gaps_on && $urandom_range(0, 5) == 0) begin
            send_idle = $urandom_range(0, 8);
          end else begin
            drive_valid = 1'b1;
            drive_beat  = pending.pop_front();
          end
        end
        pix.valid <= drive_valid;
        pix.data  <= drive_beat;
      end
    end
  end

  // --------------------------------------------------- result monitor (sink)
  // Every accepted result beat is scored against the oldest outcome waiting.
  // Ready drops at random until a random stall count runs out. It may drop while a beat is offered.
  always @(posedge clk) begin : result_monitor
    logic    take;
    result_t want;
    if (rst) begin
      res.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (awaited.size() == 0) begin
          flag_mismatch($sformatf("result beat (%0d,%0d) with nothing awaited",
                                  res.data.out_x, res.data.out_y));
        end else begin
          want = awaited.pop_front();
          check_field("out_x", 32'(res.data.out_x), 32'(want.out_x), want);
          check_field("out_y", 32'(res.data.out_y), 32'(want.out_y), want);
          check_field("escaped", 32'(res.data.escaped), 32'(want.escaped), want);
          check_field("iter_count", 32'(res.data.iter_count), 32'(want.iter_count), want);
          check_field("pixel_color", 32'(res.data.pixel_color), 32'(want.pixel_color),
                      want);
        end
      end
      take = 1'b1;
      if (recv_stall > 0) begin
        recv_stall--;
        take = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(0, 8);
        take       = 1'b0;
      end
      res.ready <= take;
    end
  end

  // ------------------------------------------------------------------ watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ----------------------------------------------------------------- sequence

  // One register write per edge. The bench copy keeps only the bits that the
  // register holds.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_MODE:         julia_on   = value[0];
      CFG_MAX_ITER:     iter_limit = value[ITER_W-1:0];
      CFG_ZOOM:         zoom_q     = value[ZOOM_W-1:0];
      CFG_SHIFT_X:      pan_x      = value;
      CFG_SHIFT_Y:      pan_y      = value;
      CFG_JULIA_RE:     jul_re     = value;
      CFG_JULIA_IM:     jul_im     = value;
      CFG_INSIDE_COLOR: inside_rgb = value[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_all(input logic [CFG_W-1:0] v_mode, v_iter, v_zoom, v_sx,
                             v_sy, v_jr, v_ji, v_rgb);
    write_reg(CFG_MODE, v_mode);
    write_reg(CFG_MAX_ITER, v_iter);
    write_reg(CFG_ZOOM, v_zoom);
    write_reg(CFG_SHIFT_X, v_sx);
    write_reg(CFG_SHIFT_Y, v_sy);
    write_reg(CFG_JULIA_RE, v_jr);
    write_reg(CFG_JULIA_IM, v_ji);
    write_reg(CFG_INSIDE_COLOR, v_rgb);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);   // queue pushes stay clear of the driver's edge
  endtask

  task automatic push_pixel(input int x, input int y);
    pixel_t p;
    p.pixel_x = PIX_W'(x);
    p.pixel_y = PIX_W'(y);
    pending.push_back(p);
  endtask

  // This holds the sender until every accepted pixel has come back. The clock then
  // runs on with nothing sent, so that register writes land on an idle engine.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending.size() != 0 || pix.valid || awaited.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // One random register setting, then a batch of random pixels. The setting
  // mostly gives zooms near 1.0, pans within +-2 and Julia points within +-1.5,
  // so that escapes fall at many iteration counts. Unused register bits get
  // random values.
  task automatic random_phase(input int count, input bit calm);
    logic [CFG_W-1:0] r_mode, r_iter, r_zoom, r_sx, r_sy, r_jr, r_ji;
    wait_drained();
    gaps_on = !calm && ($urandom_range(0, 3) != 0);
    r_mode  = $urandom();
    r_iter  = $urandom();
    r_iter[ITER_W-1:0] = ITER_W'(($urandom_range(0, 3) == 0) ? $urandom_range(49, 160)
                                                               : $urandom_range(1, 48));
    r_zoom  = $urandom();
    case ($urandom_range(0, 7))
      0:       r_zoom[ZOOM_W-1:0] = ZOOM_W'(1);
      1:       r_zoom[ZOOM_W-1:0] = ZOOM_W'(32'h7FFF_FFFF);
      default: r_zoom[ZOOM_W-1:0] = ZOOM_W'($urandom_range(32'h0400_0000, 32'h2000_0000));
    endcase
    r_sx = ($urandom_range(0, 5) == 0) ? $urandom()
                                        : $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    r_sy = ($urandom_range(0, 5) == 0) ? $urandom()
                                        : $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    r_jr = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
    r_ji = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
    program_all(r_mode, r_iter, r_zoom, r_sx, r_sy, r_jr, r_ji, $urandom());
    repeat (count) push_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.data  = '0;
    res.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The registers are still at reset (Mandelbrot, 100 iterations, zoom 1.0).
    // Corners escape before the first step is done. (-1,0) and the origin never
    // escape. (0.5,0) escapes after a few steps.
    gaps_on = 1'b1;
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    push_pixel(0, 1023);
    push_pixel(1023, 0);
    push_pixel(512, 512);
    push_pixel(256, 512);
    push_pixel(640, 512);

    // Zero iteration limit with the largest zoom. Off-centre points overflow
    // while z0 is formed. The origin takes inside_color with a count of 0.
    wait_drained();
    program_all(MANDELBROT, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 32'h00FF_FFFF);
    push_pixel(0, 0);
    push_pixel(512, 512);
    push_pixel(1023, 1023);

    // Julia at c = 0 with the largest limit. The origin runs all 4095 steps.
    // (-2,-2) overflows on the first step. (2,0) escapes at once. (1.125,0)
    // escapes at step 2 of 4095.
    wait_drained();
    program_all(JULIA, 4095, 32'h1000_0000, 0, 0, 0, 0, 0);
    push_pixel(512, 512);
    push_pixel(0, 0);
    push_pixel(1023, 512);
    push_pixel(800, 512);

    // Extreme pans and Julia point, smallest zoom. z0 sits on or past the
    // edges of the working word.
    wait_drained();
    program_all(JULIA, 1, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FF00);
    push_pixel(512, 512);
    push_pixel(1023, 1023);
    push_pixel(0, 0);

    // Pan by +2.5. At c = 2.5 the sum overflows on the first step. At c = 0.5
    // the pixel escapes later on. At c = 1.5 it escapes at once.
    wait_drained();
    program_all(MANDELBROT, 8, 32'h1000_0000, 32'h2800_0000, 0, 0, 0, 32'h0012_3456);
    push_pixel(512, 512);
    push_pixel(0, 512);
    push_pixel(256, 512);

    // A single-step limit in Mandelbrot mode.
    wait_drained();
    program_all(MANDELBROT, 1, 32'h1000_0000, 0, 0, 0, 0, 0);
    push_pixel(512, 512);
    push_pixel(384, 600);

    // Random settings. The last batch runs with no gaps on either side.
    for (int ph = 0; ph < 8; ph++) random_phase(100, ph == 7);

    wait_drained();
    repeat (200) @(negedge clk);   // any late or extra beat still gets scored

    if (mismatches == 0 && awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
